@@ sv/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// UV sphere tessellator package
// Shared sizes, table types and the elaboration-time builders of the sine,
// cosine and texture coordinate tables.
// ----------------------------------------------------------------------------
package uvs_pkg;

    // Number of latitude rows and longitude columns of the grid.
    localparam int DIVISIONS = 16;
    localparam int FULL_TURN = 4 * DIVISIONS;

    // Field widths fixed by the interface.
    localparam int IN_IDX_W = 4;
    localparam int RADIUS_W = 24;
    localparam int POS_W    = 25;
    localparam int NRM_W    = 16;
    localparam int TEX_W    = 17;

    // Grid corner index, 0 to DIVISIONS inclusive.
    localparam int IDX_W = $clog2(DIVISIONS + 1);

    // Six vertices per cell; slot counter.
    localparam int          VERTS      = 6;
    localparam int          SLOT_W     = $clog2(VERTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VERTS - 1);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] TEX_ONE     = 64'd65536;

    typedef logic signed [NRM_W-1:0]   t_q15;
    typedef logic [DIVISIONS:0][NRM_W-1:0] t_trig_tab;
    typedef logic [DIVISIONS:0][TEX_W-1:0] t_tex_tab;
    typedef logic [IDX_W-1:0]          t_idx;

    // sin(pi/2 * m / DIVISIONS) in Q1.15 by a truncated Taylor series.
    function automatic logic [63:0] quarter_sin(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] q;
        x  = (PI_HALF_Q30 * m) / DIVISIONS;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        v  = (x * t) >> 30;
        q  = (v + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q;
    endfunction

    // Sine of num quarter turns divided by DIVISIONS, folded by quadrant.
    function automatic t_q15 rom_sin(input int num);
        int          p;
        int          quad;
        int          m;
        logic [63:0] mag;
        p    = num % FULL_TURN;
        quad = p / DIVISIONS;
        m    = p % DIVISIONS;
        if (quad == 0 || quad == 2) begin
            mag = quarter_sin(64'(m));
        end else begin
            mag = quarter_sin(64'(DIVISIONS - m));
        end
        if (quad >= 2) begin
            return t_q15'(-$signed(mag[NRM_W-1:0]));
        end
        return t_q15'(mag[NRM_W-1:0]);
    endfunction

    // Table entry k holds rom_sin(mul * k + offset).
    function automatic t_trig_tab build_trig(input int mul, input int offset);
        t_trig_tab tab;
        for (int k = 0; k <= DIVISIONS; k++) begin
            tab[k] = rom_sin(mul * k + offset);
        end
        return tab;
    endfunction

    // Texture fraction k / DIVISIONS in Q.16, rounded; optionally mirrored.
    function automatic t_tex_tab build_tex(input bit mirror);
        t_tex_tab    tab;
        logic [63:0] f;
        for (int k = 0; k <= DIVISIONS; k++) begin
            f = (64'(k) * TEX_ONE + 64'(DIVISIONS / 2)) / DIVISIONS;
            if (mirror) begin
                f = TEX_ONE - f;
            end
            tab[k] = f[TEX_W-1:0];
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_LAT_TAB = build_trig(2, 3 * DIVISIONS);
    localparam t_trig_tab COS_LAT_TAB = build_trig(2, 4 * DIVISIONS);
    localparam t_trig_tab SIN_LON_TAB = build_trig(4, 0);
    localparam t_trig_tab COS_LON_TAB = build_trig(4, DIVISIONS);
    localparam t_tex_tab  TEX_U_TAB   = build_tex(1'b0);
    localparam t_tex_tab  TEX_V_TAB   = build_tex(1'b1);

endpackage

@@ sv/uv_sphere_cell_tessellator_unit.sv @@
// ----------------------------------------------------------------------------
// UV sphere cell tessellator
// Expands one latitude-longitude grid cell into the six vertices of its two
// triangles, with position, unit normal and texture coordinates.
// ----------------------------------------------------------------------------
// A cell is taken when i_start is high and o_busy is low. The block then
// emits six vertices, one per clock cycle, in the order a, b, c, b, d, c,
// where a is (lat, lon), b is (lat+1, lon), c is (lat, lon+1) and d is
// (lat+1, lon+1). Each vertex word is on the output ports for exactly one
// cycle, marked by o_vertex_valid; the receiver cannot stall, so it must take
// every word as it comes. The words of a cell pass through the vertex
// sequencer and the pipeline stages and come out in consecutive cycles.
// o_busy is high until the sequencer issues the last vertex of a cell, and a
// new cell can be taken in that same cycle: the single vertex sequencer
// issues one vertex per clock. The last word of each cell carries
// o_last_vertex. The radius register is written through the configuration
// channel, which is always ready; it must only be written while no cell is
// in flight.
// ----------------------------------------------------------------------------
module uv_sphere_cell_tessellator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Cell command channel
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [uvs_pkg::IN_IDX_W-1:0]     i_lat_index,
    input  logic [uvs_pkg::IN_IDX_W-1:0]     i_lon_index,
    // Radius configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [uvs_pkg::RADIUS_W-1:0]     i_cfg_radius,
    // Vertex output
    output logic                             o_vertex_valid,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_z,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_z,
    output logic [uvs_pkg::TEX_W-1:0]        o_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]        o_tex_v,
    output logic                             o_last_vertex
);
    import uvs_pkg::*;

    localparam int PROD_W = RADIUS_W + 1 + NRM_W;
    localparam int NPROD_W = 2 * NRM_W;

    // ------------------------------------------------------------------
    // Configuration register. Always ready; the user must write it only while idle, the block does not enforce this.
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0] r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radius <= i_cfg_radius;
        end
    end

    // ------------------------------------------------------------------
    // Vertex sequencer: holds the current cell and steps through the six
    // vertex slots, one per cycle. The next cell may be taken in the cycle
    // that issues the last slot, so cells follow without a gap.
    // ------------------------------------------------------------------
    logic              r_active, n_active;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_idx              r_lat, n_lat;
    t_idx              r_lon, n_lon;
    logic              take_cell;
    t_idx              sat_lat;
    t_idx              sat_lon;
    t_idx              issue_lat;
    t_idx              issue_lon;

    assign o_busy    = r_active && (r_slot != LAST_SLOT);
    assign take_cell = i_start && !o_busy;

    // Indices beyond the grid are clamped to the last row or column.
    always_comb begin
        if (int'(i_lat_index) > DIVISIONS - 1) begin
            sat_lat = IDX_W'(DIVISIONS - 1);
        end else begin
            sat_lat = IDX_W'(i_lat_index);
        end
        if (int'(i_lon_index) > DIVISIONS - 1) begin
            sat_lon = IDX_W'(DIVISIONS - 1);
        end else begin
            sat_lon = IDX_W'(i_lon_index);
        end
    end

    always_comb begin
        n_active = r_active;
        n_slot   = r_slot;
        n_lat    = r_lat;
        n_lon    = r_lon;
        if (take_cell) begin
            n_active = 1'b1;
            n_slot   = '0;
            n_lat    = sat_lat;
            n_lon    = sat_lon;
        end else if (r_active) begin
            if (r_slot == LAST_SLOT) begin
                n_active = 1'b0;
            end else begin
                n_slot = r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_slot   <= '0;
        end else begin
            r_active <= n_active;
            r_slot   <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat <= n_lat;
        r_lon <= n_lon;
    end

    // Corner of the current slot: a, b, c, b, d, c.
    always_comb begin
        issue_lat = r_lat;
        issue_lon = r_lon;
        case (r_slot) inside
            3'd1, 3'd3: begin
                issue_lat = r_lat + 1'b1;
            end
            3'd2, 3'd5: begin
                issue_lon = r_lon + 1'b1;
            end
            3'd4: begin
                issue_lat = r_lat + 1'b1;
                issue_lon = r_lon + 1'b1;
            end
            default: begin
                issue_lat = r_lat;
                issue_lon = r_lon;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: registered corner indices.
    // ------------------------------------------------------------------
    logic r_v1;
    t_idx r_s1_lat;
    t_idx r_s1_lon;
    logic r_s1_last;

    always_ff @(posedge i_clk) begin
        r_s1_lat  <= issue_lat;
        r_s1_lon  <= issue_lon;
        r_s1_last <= (r_slot == LAST_SLOT);
    end

    // ------------------------------------------------------------------
    // Stage 2: sine, cosine and texture table lookups.
    // ------------------------------------------------------------------
    logic               r_v2;
    t_q15               r_s2_slat;
    t_q15               r_s2_clat;
    t_q15               r_s2_slon;
    t_q15               r_s2_clon;
    logic [TEX_W-1:0]   r_s2_u;
    logic [TEX_W-1:0]   r_s2_v;
    logic               r_s2_last;

    always_ff @(posedge i_clk) begin
        r_s2_slat <= SIN_LAT_TAB[r_s1_lat];
        r_s2_clat <= COS_LAT_TAB[r_s1_lat];
        r_s2_slon <= SIN_LON_TAB[r_s1_lon];
        r_s2_clon <= COS_LON_TAB[r_s1_lon];
        r_s2_u    <= TEX_U_TAB[r_s1_lon];
        r_s2_v    <= TEX_V_TAB[r_s1_lat];
        r_s2_last <= r_s1_last;
    end

    // ------------------------------------------------------------------
    // Stage 3: unit normal. x and z are products of two Q1.15 values,
    // rounded half away from zero back to Q1.15; y is sin(lat) directly.
    // Adding 2^14 - 1 to a negative value before an arithmetic shift gives
    // the same result as rounding its magnitude.
    // ------------------------------------------------------------------
    logic               r_v3;
    t_q15               r_s3_nx;
    t_q15               r_s3_ny;
    t_q15               r_s3_nz;
    logic [TEX_W-1:0]   r_s3_u;
    logic [TEX_W-1:0]   r_s3_v;
    logic               r_s3_last;
    logic signed [NPROD_W-1:0] prod_x;
    logic signed [NPROD_W-1:0] prod_z;
    logic signed [NPROD_W-1:0] rnd_x;
    logic signed [NPROD_W-1:0] rnd_z;

    always_comb begin
        prod_x = r_s2_clat * r_s2_clon;
        prod_z = r_s2_clat * r_s2_slon;
        rnd_x  = prod_x + (prod_x[NPROD_W-1] ? NPROD_W'(16383) : NPROD_W'(16384));
        rnd_z  = prod_z + (prod_z[NPROD_W-1] ? NPROD_W'(16383) : NPROD_W'(16384));
    end

    always_ff @(posedge i_clk) begin
        r_s3_nx   <= rnd_x[NRM_W+14:15];
        r_s3_ny   <= r_s2_slat;
        r_s3_nz   <= rnd_z[NRM_W+14:15];
        r_s3_u    <= r_s2_u;
        r_s3_v    <= r_s2_v;
        r_s3_last <= r_s2_last;
    end

    // ------------------------------------------------------------------
    // Stage 4: radius times each normal component. The products are formed
    // at their full width so that no high bits are lost.
    // ------------------------------------------------------------------
    logic                     r_v4;
    logic signed [PROD_W-1:0] r_s4_px;
    logic signed [PROD_W-1:0] r_s4_py;
    logic signed [PROD_W-1:0] r_s4_pz;
    t_q15                     r_s4_nx;
    t_q15                     r_s4_ny;
    t_q15                     r_s4_nz;
    logic [TEX_W-1:0]         r_s4_u;
    logic [TEX_W-1:0]         r_s4_v;
    logic                     r_s4_last;
    logic signed [RADIUS_W:0] radius_s;
    logic signed [PROD_W-1:0] mul_px;
    logic signed [PROD_W-1:0] mul_py;
    logic signed [PROD_W-1:0] mul_pz;

    assign radius_s = $signed({1'b0, r_radius});

    always_comb begin
        mul_px = radius_s * r_s3_nx;
        mul_py = radius_s * r_s3_ny;
        mul_pz = radius_s * r_s3_nz;
    end

    always_ff @(posedge i_clk) begin
        r_s4_px   <= mul_px;
        r_s4_py   <= mul_py;
        r_s4_pz   <= mul_pz;
        r_s4_nx   <= r_s3_nx;
        r_s4_ny   <= r_s3_ny;
        r_s4_nz   <= r_s3_nz;
        r_s4_u    <= r_s3_u;
        r_s4_v    <= r_s3_v;
        r_s4_last <= r_s3_last;
    end

    // ------------------------------------------------------------------
    // Stage 5: round the positions to Q8.16 and drive the output word.
    // ------------------------------------------------------------------
    logic                     r_v5;
    logic signed [PROD_W-1:0] rnd_px;
    logic signed [PROD_W-1:0] rnd_py;
    logic signed [PROD_W-1:0] rnd_pz;

    always_comb begin
        rnd_px = r_s4_px + (r_s4_px[PROD_W-1] ? PROD_W'(16383) : PROD_W'(16384));
        rnd_py = r_s4_py + (r_s4_py[PROD_W-1] ? PROD_W'(16383) : PROD_W'(16384));
        rnd_pz = r_s4_pz + (r_s4_pz[PROD_W-1] ? PROD_W'(16383) : PROD_W'(16384));
    end

    always_ff @(posedge i_clk) begin
        o_pos_x       <= rnd_px[POS_W+14:15];
        o_pos_y       <= rnd_py[POS_W+14:15];
        o_pos_z       <= rnd_pz[POS_W+14:15];
        o_normal_x    <= r_s4_nx;
        o_normal_y    <= r_s4_ny;
        o_normal_z    <= r_s4_nz;
        o_tex_u       <= r_s4_u;
        o_tex_v       <= r_s4_v;
        o_last_vertex <= r_s4_last;
    end

    // Valid bits travel alongside the vertex data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= r_active;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign o_vertex_valid = r_v5;

endmodule
